// ===== rtl/bpc_pkg.sv =====
// shared types and constants for the barometric pressure compensation block
// no dependencies; every file but the two interfaces refers to this package by scoped names
package bpc_pkg;

    // configuration port geometry
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;

    // register indexes, byte address is four times the index
    localparam logic [REG_IDX_W-1:0] REG_PRESSURE_SENS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRESSURE_OFF  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SENS_TC       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFF_TC        = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REF_TEMP      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_COEFF    = 3'd5;
    localparam logic [REG_IDX_W-1:0] NUM_REGS          = 3'd6;

    // distance between the 20.00 C and -15.00 C thresholds in 0.01 C
    localparam logic signed [19:0] LOW_TEMP_OFS = 20'sd3500;

    // calibration words as held in the register bank
    typedef struct packed {
        logic [15:0] pressure_sensitivity;
        logic [15:0] pressure_offset;
        logic [15:0] sensitivity_temp_coeff;
        logic [15:0] offset_temp_coeff;
        logic [15:0] reference_temperature;
        logic [15:0] temperature_coeff;
    } cal_t;

    // first-order terms: temperature delta from 20.00 C, offset, sensitivity
    typedef struct packed {
        logic [23:0]        d1;
        logic signed [18:0] tdel;
        logic signed [37:0] off1;
        logic signed [36:0] sens1;
    } fo_t;

    // offset and sensitivity after second-order correction
    typedef struct packed {
        logic [23:0]        d1;
        logic signed [43:0] off;
        logic signed [43:0] sens;
    } so_t;

endpackage

// ===== rtl/bpc_sample_if.sv =====
// input channel carrying one raw pressure and temperature conversion pair
// depends on nothing
interface bpc_sample_if;
    logic        valid;
    logic        ready;
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ===== rtl/bpc_result_if.sv =====
// output channel carrying one compensated pressure
// depends on nothing
interface bpc_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pressure;

    modport source (output valid, output pressure, input ready);
    modport sink (input valid, input pressure, output ready);
endinterface

// ===== rtl/baro_pressure_compensation_top.sv =====
// top level of the second-order barometric pressure compensation pipeline
// depends on bpc_pkg, bpc_sample_if, bpc_result_if, bpc_cfg_regs,
// bpc_first_order, bpc_second_order, bpc_scale
//
// usage:
//   sample carries one raw pressure / raw temperature conversion pair per item,
//   result carries the compensated pressure in 0.01 mbar, low 32 bits.
//   the six calibration words sit on the apb port at byte addresses 0 to 20;
//   write them while no item is in flight.
// timing:
//   nine register stages, each with its own valid bit; the ninth is the
//   output register. one item per cycle sustained while result is taken;
//   the longest stage is one 26x17 multiply or one 25x22 partial product
//   of D1 times sensitivity.
// reset:
//   rst_n clears all stage valid bits and the calibration words to zero.
// stall:
//   when result is held off, stages fill up behind the output register and
//   sample.ready drops only once all nine stages are occupied;
//   no item is lost or repeated.
module baro_pressure_compensation_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    bpc_sample_if.sink                  sample,
    bpc_result_if.source                result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    bpc_pkg::cal_t cal;
    bpc_pkg::fo_t  fo_data;
    bpc_pkg::so_t  so_data;
    logic          fo_valid, fo_ready;
    logic          so_valid, so_ready;

    // calibration registers
    bpc_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    // first-order terms
    bpc_first_order u_first
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cal             (cal),
        .in_valid        (sample.valid),
        .in_ready        (sample.ready),
        .raw_pressure    (sample.raw_pressure),
        .raw_temperature (sample.raw_temperature),
        .out_valid       (fo_valid),
        .out_ready       (fo_ready),
        .out_data        (fo_data)
    );

    // low-temperature correction
    bpc_second_order u_second
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fo_valid),
        .in_ready  (fo_ready),
        .in_data   (fo_data),
        .out_valid (so_valid),
        .out_ready (so_ready),
        .out_data  (so_data)
    );

    // pressure scaling and output register
    bpc_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (so_valid),
        .in_ready  (so_ready),
        .in_data   (so_data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .pressure  (result.pressure)
    );

endmodule

// ===== rtl/bpc_cfg_regs.sv =====
// apb register bank holding the six calibration words
// depends on bpc_pkg
module bpc_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output bpc_pkg::cal_t               cal
);

    bpc_pkg::cal_t                 cal_reg;
    bpc_pkg::cal_t                 cal_next;
    logic [bpc_pkg::REG_IDX_W-1:0] idx;
    logic                          wr_en;

    assign idx    = paddr[bpc_pkg::PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cal    = cal_reg;

    // write decode, addresses past the list are dropped
    always_comb
    begin
        cal_next = cal_reg;
        if (wr_en)
        begin
            case (idx)
                bpc_pkg::REG_PRESSURE_SENS: cal_next.pressure_sensitivity   = pwdata[15:0];
                bpc_pkg::REG_PRESSURE_OFF:  cal_next.pressure_offset        = pwdata[15:0];
                bpc_pkg::REG_SENS_TC:       cal_next.sensitivity_temp_coeff = pwdata[15:0];
                bpc_pkg::REG_OFF_TC:        cal_next.offset_temp_coeff      = pwdata[15:0];
                bpc_pkg::REG_REF_TEMP:      cal_next.reference_temperature  = pwdata[15:0];
                bpc_pkg::REG_TEMP_COEFF:    cal_next.temperature_coeff      = pwdata[15:0];
                default:                    cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            bpc_pkg::REG_PRESSURE_SENS: prdata = {16'd0, cal_reg.pressure_sensitivity};
            bpc_pkg::REG_PRESSURE_OFF:  prdata = {16'd0, cal_reg.pressure_offset};
            bpc_pkg::REG_SENS_TC:       prdata = {16'd0, cal_reg.sensitivity_temp_coeff};
            bpc_pkg::REG_OFF_TC:        prdata = {16'd0, cal_reg.offset_temp_coeff};
            bpc_pkg::REG_REF_TEMP:      prdata = {16'd0, cal_reg.reference_temperature};
            bpc_pkg::REG_TEMP_COEFF:    prdata = {16'd0, cal_reg.temperature_coeff};
            default:                    prdata = '0;
        endcase
    end

endmodule

// ===== rtl/bpc_first_order.sv =====
// stages 1 to 3: temperature difference, coefficient products, first-order terms
// depends on bpc_pkg
module bpc_first_order
(
    input  logic          clk,
    input  logic          rst_n,
    input  bpc_pkg::cal_t cal,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [23:0]   raw_pressure,
    input  logic [23:0]   raw_temperature,
    output logic          out_valid,
    input  logic          out_ready,
    output bpc_pkg::fo_t  out_data
);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    logic [23:0]        d1_s1_reg, d1_s1_next;
    logic signed [25:0] dt_reg, dt_next;
    logic [23:0]        d1_s2_reg;
    logic signed [42:0] p6_reg, p6_next;
    logic signed [42:0] p4_reg, p4_next;
    logic signed [42:0] p3_reg, p3_next;
    bpc_pkg::fo_t       fo_reg, fo_next;

    logic signed [42:0] p6_adj, p4_adj, p3_adj;
    logic signed [35:0] q4;
    logic signed [34:0] q3;

    // stage handshake, a stage loads when it is empty or its successor moves
    assign rdy3      = !v3_reg || out_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v3_reg;
    assign out_data  = fo_reg;

    // stage 1: dT = D2 - C5 * 256
    always_comb
    begin
        d1_s1_next = raw_pressure;
        dt_next    = $signed({2'b00, raw_temperature})
                   - $signed({2'b00, cal.reference_temperature, 8'h00});
    end

    // stage 2: the three products against dT
    always_comb
    begin
        p6_next = dt_reg * $signed({1'b0, cal.temperature_coeff});
        p4_next = dt_reg * $signed({1'b0, cal.offset_temp_coeff});
        p3_next = dt_reg * $signed({1'b0, cal.sensitivity_temp_coeff});
    end

    // stage 3: truncating shifts and the base terms
    always_comb
    begin
        p6_adj = p6_reg + $signed({20'd0, {23{p6_reg[42]}}});
        p4_adj = p4_reg + $signed({36'd0, {7{p4_reg[42]}}});
        p3_adj = p3_reg + $signed({35'd0, {8{p3_reg[42]}}});
        q4     = p4_adj[42:7];
        q3     = p3_adj[42:8];
        fo_next.d1    = d1_s2_reg;
        fo_next.tdel  = p6_adj[41:23];
        fo_next.off1  = $signed({6'd0, cal.pressure_offset, 16'd0}) + q4;
        fo_next.sens1 = $signed({6'd0, cal.pressure_sensitivity, 15'd0}) + q3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // payload moves only with a valid item
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            d1_s1_reg <= d1_s1_next;
            dt_reg    <= dt_next;
        end
        if (rdy2 && v1_reg)
        begin
            d1_s2_reg <= d1_s1_reg;
            p6_reg    <= p6_next;
            p4_reg    <= p4_next;
            p3_reg    <= p3_next;
        end
        if (rdy3 && v2_reg)
        begin
            fo_reg <= fo_next;
        end
    end

endmodule

// ===== rtl/bpc_second_order.sv =====
// stages 4 and 5: low-temperature squares and second-order correction
// depends on bpc_pkg
module bpc_second_order
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  bpc_pkg::fo_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output bpc_pkg::so_t out_data
);

    logic v4_reg, v5_reg;
    logic rdy4, rdy5;

    logic signed [18:0] d;
    logic signed [19:0] e;
    logic signed [37:0] sq_d;
    logic signed [39:0] sq_e;

    logic [23:0]        d1_s4_reg, d1_s4_next;
    logic signed [37:0] off1_reg, off1_next;
    logic signed [36:0] sens1_reg, sens1_next;
    logic [36:0]        dd_reg, dd_next;
    logic [38:0]        ee_reg, ee_next;
    logic               lt_ref_reg, lt_ref_next;
    logic               lt_low_reg, lt_low_next;
    bpc_pkg::so_t       so_reg, so_next;

    logic [38:0] dd5;
    logic [41:0] ee7;
    logic [42:0] ee11;
    logic [42:0] off2, sens2;

    assign rdy5      = !v5_reg || out_ready;
    assign rdy4      = !v4_reg || rdy5;
    assign in_ready  = rdy4;
    assign out_valid = v5_reg;
    assign out_data  = so_reg;

    // stage 4: squares of the distances below both thresholds
    always_comb
    begin
        d           = in_data.tdel;
        e           = {d[18], d} + bpc_pkg::LOW_TEMP_OFS;
        sq_d        = d * d;
        sq_e        = e * e;
        dd_next     = sq_d[36:0];
        ee_next     = sq_e[38:0];
        lt_ref_next = d[18];
        lt_low_next = e[19];
        d1_s4_next  = in_data.d1;
        off1_next   = in_data.off1;
        sens1_next  = in_data.sens1;
    end

    // stage 5: weighted corrections subtracted from offset and sensitivity
    always_comb
    begin
        dd5   = {dd_reg, 2'b00} + 39'(dd_reg);
        ee7   = {ee_reg, 3'b000} - 42'(ee_reg);
        ee11  = {ee_reg, 3'b000} + 43'({ee_reg, 1'b0}) + 43'(ee_reg);
        off2  = (lt_ref_reg ? 43'(dd5[38:1]) : 43'd0)
              + (lt_low_reg ? 43'(ee7) : 43'd0);
        sens2 = (lt_ref_reg ? 43'(dd5[38:2]) : 43'd0)
              + (lt_low_reg ? 43'(ee11[42:1]) : 43'd0);
        so_next.d1   = d1_s4_reg;
        so_next.off  = 44'(off1_reg) - $signed({1'b0, off2});
        so_next.sens = 44'(sens1_reg) - $signed({1'b0, sens2});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
            begin
                v4_reg <= in_valid;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && in_valid)
        begin
            d1_s4_reg  <= d1_s4_next;
            off1_reg   <= off1_next;
            sens1_reg  <= sens1_next;
            dd_reg     <= dd_next;
            ee_reg     <= ee_next;
            lt_ref_reg <= lt_ref_next;
            lt_low_reg <= lt_low_next;
        end
        if (rdy5 && v4_reg)
        begin
            so_reg <= so_next;
        end
    end

endmodule

// ===== rtl/bpc_scale.sv =====
// stages 6 to 9: D1 times sensitivity in two partial products, offset, final scaling
// depends on bpc_pkg
module bpc_scale
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bpc_pkg::so_t       in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pressure
);

    logic v6_reg, v7_reg, v8_reg, v9_reg;
    logic rdy6, rdy7, rdy8, rdy9;

    logic [45:0]        pp_lo_reg, pp_lo_next;
    logic signed [46:0] pp_hi_reg, pp_hi_next;
    logic signed [43:0] off_s6_reg, off_s7_reg;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [44:0] diff_reg, diff_next;
    logic signed [31:0] res_reg, res_next;

    logic signed [68:0] prod_full;
    logic signed [63:0] prod_adj;
    logic signed [42:0] q21;
    logic signed [44:0] diff_adj;
    logic signed [29:0] q15;

    assign rdy9      = !v9_reg || out_ready;
    assign rdy8      = !v8_reg || rdy9;
    assign rdy7      = !v7_reg || rdy8;
    assign rdy6      = !v6_reg || rdy7;
    assign in_ready  = rdy6;
    assign out_valid = v9_reg;
    assign pressure  = res_reg;

    // stage 6: sensitivity split into a low unsigned and a high signed half
    always_comb
    begin
        pp_lo_next = in_data.d1 * in_data.sens[21:0];
        pp_hi_next = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[43:22]);
    end

    // stage 7: recombine the halves
    always_comb
    begin
        prod_full = $signed({pp_hi_reg, 22'd0}) + $signed({23'd0, pp_lo_reg});
        prod_next = prod_full[63:0];
    end

    // stage 8: truncate by 2^21 and take off the offset
    always_comb
    begin
        prod_adj  = prod_reg + $signed({43'd0, {21{prod_reg[63]}}});
        q21       = prod_adj[63:21];
        diff_next = 45'(q21) - 45'(off_s7_reg);
    end

    // stage 9: truncate by 2^15, keep 32 bits
    always_comb
    begin
        diff_adj = diff_reg + $signed({30'd0, {15{diff_reg[44]}}});
        q15      = diff_adj[44:15];
        res_next = 32'(q15);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else
        begin
            if (rdy6)
            begin
                v6_reg <= in_valid;
            end
            if (rdy7)
            begin
                v7_reg <= v6_reg;
            end
            if (rdy8)
            begin
                v8_reg <= v7_reg;
            end
            if (rdy9)
            begin
                v9_reg <= v8_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy6 && in_valid)
        begin
            pp_lo_reg  <= pp_lo_next;
            pp_hi_reg  <= pp_hi_next;
            off_s6_reg <= in_data.off;
        end
        if (rdy7 && v6_reg)
        begin
            prod_reg   <= prod_next;
            off_s7_reg <= off_s6_reg;
        end
        if (rdy8 && v7_reg)
        begin
            diff_reg <= diff_next;
        end
        if (rdy9 && v8_reg)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== rtl/bpc_checker.sv =====
// port-level checks for the pressure compensation top and their bind
// depends on bpc_pkg and baro_pressure_compensation_top
module bpc_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        sample_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic signed [31:0]          result_pressure,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [bpc_pkg::PADDR_W-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata
);

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite
                 && (paddr[bpc_pkg::PADDR_W-1:2] < bpc_pkg::NUM_REGS);

    // a stalled result stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_pressure))
        else $error("result changed while stalled");

    // with the output draining, the pipeline always takes a new item
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> sample_ready)
        else $error("input blocked while output drains");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        $past(!rst_n) |-> !result_valid)
        else $error("result offered right after reset");

    // a calibration word reads back what was just written
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cfg_wr) && (paddr == $past(paddr)) |-> prdata == {16'd0, $past(pwdata[15:0])})
        else $error("calibration readback mismatch");

endmodule

bind baro_pressure_compensation_top bpc_checker u_bpc_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .sample_ready    (sample.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_pressure (result.pressure),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
);
